[design/tkhi_pkg.sv]
package tkhi_pkg;

    // request modes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_APPENDED = 3'd1;
    localparam logic [2:0] ST_MISS     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    // 64-bit finaliser multipliers
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] source_id;
        logic [31:0] revision;
        logic [31:0] vertex_total;
        logic [31:0] index_total;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] entry_number;
    } t_out_item;

    typedef struct packed {
        logic [63:0] source_id;
        logic [31:0] revision;
        logic [31:0] vertex_total;
        logic [31:0] index_total;
    } t_key;

endpackage

[design/tuple_key_hash_index_top.sv]
// an item is hashed, then the slots are probed from its home slot on, each occupied slot adding a
// key compare and a hit ending the probe; rejected and unused-mode items go straight to the result
// throughput: one item in flight, most of its time spent in the hash
// (one 32x32 multiplier, 6 multiplies); a clear request takes a clearing pass over every slot
// reset: synchronous active low; a clearing pass over every slot follows, with input stalled
// key memory holds no reset value; only entries below the entry count are ever read
module tuple_key_hash_index_top #(
    parameter int ENTRY_DEPTH = 256,
    parameter int SLOT_DEPTH  = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tkhi_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tkhi_pkg::t_out_item o_out_item
);

    localparam int SLOT_W  = $clog2(SLOT_DEPTH);
    localparam int ENTRY_W = $clog2(ENTRY_DEPTH);
    localparam int COUNT_W = $clog2(ENTRY_DEPTH + 1);
    localparam int KEY_W   = $bits(tkhi_pkg::t_key);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_SLOT  = 3'd3;
    localparam logic [2:0] S_KEY   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]          r_state,     n_state;
    tkhi_pkg::t_in_item  r_req,       n_req;
    logic [SLOT_W-1:0]   r_slot,      n_slot;
    logic [SLOT_W-1:0]   r_probe,     n_probe;
    logic [ENTRY_W-1:0]  r_entry,     n_entry;
    logic [COUNT_W-1:0]  r_count,     n_count;
    logic [SLOT_W-1:0]   r_clr_addr,  n_clr_addr;
    logic                r_clr_reply, n_clr_reply;
    tkhi_pkg::t_out_item r_res,       n_res;
    logic                r_out_valid, n_out_valid;
    tkhi_pkg::t_out_item r_out_item,  n_out_item;

    // slot memory: valid bit above entry number
    logic                slot_wr_en;
    logic [SLOT_W-1:0]   slot_wr_addr;
    logic [ENTRY_W:0]    slot_wr_data;
    logic                slot_rd_en;
    logic [SLOT_W-1:0]   slot_rd_addr;
    logic [ENTRY_W:0]    slot_rd_data;
    logic                slot_valid;
    logic [ENTRY_W-1:0]  slot_entry;

    // key memory
    logic                key_wr_en;
    logic [KEY_W-1:0]    key_wr_data;
    logic                key_rd_en;
    logic [KEY_W-1:0]    key_rd_data;
    tkhi_pkg::t_key      req_key;

    // hash unit
    logic                hash_start;
    tkhi_pkg::t_in_item  hash_item;
    logic                hash_done;
    logic [SLOT_W-1:0]   hash_slot;

    // entry numbers widened then cut to the 8-bit result field
    logic [ENTRY_W+7:0]  app_wide;
    logic [ENTRY_W+7:0]  hit_wide;
    logic [SLOT_W-1:0]   next_slot;

    assign slot_valid = slot_rd_data[ENTRY_W];
    assign slot_entry = slot_rd_data[ENTRY_W-1:0];
    assign req_key    = '{source_id:    r_req.source_id,
                          revision:     r_req.revision,
                          vertex_total: r_req.vertex_total,
                          index_total:  r_req.index_total};
    assign key_wr_data = req_key;
    assign app_wide    = {8'd0, r_count[ENTRY_W-1:0]};
    assign hit_wide    = {8'd0, r_entry};
    assign next_slot   = r_slot + SLOT_W'(1);

    // the hash reads the source at start and the other key parts later
    assign hash_item = (r_state == S_IDLE) ? i_in_item : r_req;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_slot      = r_slot;
        n_probe     = r_probe;
        n_entry     = r_entry;
        n_count     = r_count;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;

        slot_wr_en   = 1'b0;
        slot_wr_addr = r_slot;
        slot_wr_data = '0;
        slot_rd_en   = 1'b0;
        slot_rd_addr = r_slot;
        key_wr_en    = 1'b0;
        key_rd_en    = 1'b0;
        hash_start   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // empty one slot a cycle
                slot_wr_en   = 1'b1;
                slot_wr_addr = r_clr_addr;
                n_clr_addr   = r_clr_addr + SLOT_W'(1);
                if (r_clr_addr == '1) begin
                    n_state     = r_clr_reply ? S_FIN : S_IDLE;
                    n_clr_reply = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_item;
                    n_res = '{status: tkhi_pkg::ST_CLEARED, entry_number: 8'd0};
                    if (i_in_item.mode == tkhi_pkg::MODE_CLEAR) begin
                        n_count     = '0;
                        n_clr_addr  = '0;
                        n_clr_reply = 1'b1;
                        n_state     = S_CLEAR;
                    end else if ((i_in_item.mode == tkhi_pkg::MODE_LOOKUP ||
                                  i_in_item.mode == tkhi_pkg::MODE_APPEND) &&
                                 i_in_item.source_id != 64'd0) begin
                        hash_start = 1'b1;
                        n_state    = S_HASH;
                    end else begin
                        // unused mode or no source
                        n_state = S_FIN;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_slot       = hash_slot;
                    n_probe      = '0;
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = hash_slot;
                    n_state      = S_SLOT;
                end
            end
            S_SLOT: begin
                if (!slot_valid) begin
                    n_state = S_FIN;
                    if (r_req.mode == tkhi_pkg::MODE_LOOKUP) begin
                        n_res.status = tkhi_pkg::ST_MISS;
                    end else if (r_count == COUNT_W'(ENTRY_DEPTH)) begin
                        n_res.status = tkhi_pkg::ST_FULL;
                    end else begin
                        // append at the empty slot, next sequential entry
                        key_wr_en          = 1'b1;
                        slot_wr_en         = 1'b1;
                        slot_wr_addr       = r_slot;
                        slot_wr_data       = {1'b1, r_count[ENTRY_W-1:0]};
                        n_count            = r_count + COUNT_W'(1);
                        n_res.status       = tkhi_pkg::ST_APPENDED;
                        n_res.entry_number = app_wide[7:0];
                    end
                end else begin
                    key_rd_en = 1'b1;
                    n_entry   = slot_entry;
                    n_state   = S_KEY;
                end
            end
            S_KEY: begin
                if (key_rd_data == KEY_W'(req_key)) begin
                    n_res.status       = tkhi_pkg::ST_FOUND;
                    n_res.entry_number = hit_wide[7:0];
                    n_state            = S_FIN;
                end else if (r_probe == '1) begin
                    // every slot visited, none empty
                    n_res.status = (r_req.mode == tkhi_pkg::MODE_LOOKUP) ?
                                   tkhi_pkg::ST_MISS : tkhi_pkg::ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    n_probe      = r_probe + SLOT_W'(1);
                    n_slot       = next_slot;
                    slot_rd_en   = 1'b1;
                    slot_rd_addr = next_slot;
                    n_state      = S_SLOT;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_slot     <= n_slot;
        r_probe    <= n_probe;
        r_entry    <= n_entry;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    tkhi_hash #(
        .SLOT_W (SLOT_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_item  (hash_item),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    tkhi_ram #(
        .WIDTH (ENTRY_W + 1),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (slot_wr_addr),
        .i_wr_data (slot_wr_data),
        .i_rd_en   (slot_rd_en),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd_data)
    );

    tkhi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRY_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr_en),
        .i_wr_addr (r_count[ENTRY_W-1:0]),
        .i_wr_data (key_wr_data),
        .i_rd_en   (key_rd_en),
        .i_rd_addr (slot_entry),
        .o_rd_data (key_rd_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[design/tkhi_ram.sv]
module tkhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/tkhi_hash.sv]
module tkhi_hash #(
    parameter int SLOT_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tkhi_pkg::t_in_item i_item,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_slot
);

    // three rounds, two multiplies each, four steps per multiply
    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic        r_mul;
    logic [1:0]  r_round;
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [SLOT_W-1:0] r_slot;

    logic [63:0] coef;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] mp;
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] inj;
    logic [63:0] src;

    assign coef = r_mul ? tkhi_pkg::MIX_C2 : tkhi_pkg::MIX_C1;
    assign ma   = (r_step == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign mb   = (r_step == 2'd1) ? coef[63:32] : coef[31:0];
    assign mp   = ma * mb;

    // low 64 bits of the full product: only low halves of the cross terms count
    assign p   = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
    assign y   = p ^ (p >> 31);
    assign inj = (r_round == 2'd0) ? {i_item.revision, 32'd0}
                                   : ({16'd0, i_item.vertex_total, 16'd0}
                                      ^ {32'd0, i_item.index_total});
    assign z   = y ^ inj;
    assign src = i_item.source_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_step  <= 2'd0;
            r_mul   <= 1'b0;
            r_round <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_step  <= 2'd0;
                r_mul   <= 1'b0;
                r_round <= 2'd0;
                r_x     <= src ^ (src >> 30);
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                r_prod <= mp;
                case (r_step)
                    2'd1: begin
                        r_acc <= r_prod;
                    end
                    2'd2: begin
                        r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                    end
                    2'd3: begin
                        if (!r_mul) begin
                            r_x   <= p ^ (p >> 27);
                            r_mul <= 1'b1;
                        end else if (r_round == 2'd2) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_slot <= (y == 64'd0) ? SLOT_W'(1) : y[SLOT_W-1:0];
                        end else begin
                            r_x     <= z ^ (z >> 30);
                            r_mul   <= 1'b0;
                            r_round <= r_round + 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_slot = r_slot;

endmodule

[design/tkhi_checker.sv]
module tkhi_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input tkhi_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tkhi_pkg::t_out_item o_out_item
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // only found and appended results carry an entry number
    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == tkhi_pkg::ST_MISS ||
                        o_out_item.status == tkhi_pkg::ST_FULL ||
                        o_out_item.status == tkhi_pkg::ST_CLEARED)
        |-> o_out_item.entry_number == 8'd0)
        else $error("entry number set on a non-hit result");

    // clearing pass after reset keeps the input stalled
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open straight after reset");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in flight");

endmodule

bind tuple_key_hash_index_top tkhi_checker u_tkhi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
